FILE: hdl/csv_field_number_classifier_top_assert.svh
// assertion macros shared by the classifier modules
// they expect clk and rst in scope
`ifndef CSV_FIELD_NUMBER_CLASSIFIER_TOP_ASSERT_SVH
`define CSV_FIELD_NUMBER_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define CFNC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cfnc_pkg.sv
package cfnc_pkg;

  // scan phase codes
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_MANT  = 3'd1;
  localparam logic [2:0] PH_EXPS  = 3'd2;
  localparam logic [2:0] PH_EXPD  = 3'd3;
  localparam logic [2:0] PH_TRAIL = 3'd4;
  localparam logic [2:0] PH_FAIL  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_EXP   = 8'h65;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] SEP_RESET = 8'h2C;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] points;
    logic       digit;
  } scan_t;

  typedef struct packed {
    logic [7:0] column_index;
    logic       is_numeric;
    logic       column_overflow;
    logic       last_field;
  } result_t;

  // zero, one or two results from one item, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // phase after the mantissa or exponent ends
  function automatic logic [2:0] after_number(input logic [7:0] c);
    logic [2:0] ph;
    if (c == CH_SPACE) begin
      ph = PH_TRAIL;
    end else if (c == CH_NUL) begin
      ph = PH_DONE;
    end else begin
      ph = PH_FAIL;
    end
    return ph;
  endfunction

  // one byte of number recognition
  function automatic scan_t feed(input scan_t s, input logic [7:0] c);
    scan_t n;
    n = s;
    unique case (s.phase)
      PH_LEAD: begin
        if (c == CH_SPACE) begin
          n = s;
        end else if (is_sign(c)) begin
          n.phase = PH_MANT;
        end else if (is_digit(c)) begin
          n.digit = 1'b1;
          n.phase = PH_MANT;
        end else if (c == CH_POINT) begin
          n.points = 2'd1;
          n.phase = PH_MANT;
        end else begin
          n.phase = PH_FAIL;
        end
      end
      PH_MANT: begin
        if (is_digit(c)) begin
          n.digit = 1'b1;
        end else if (c == CH_POINT) begin
          if (s.points < 2'd2) begin
            n.points = s.points + 2'd1;
          end
        end else if ((s.points > 2'd1) || !s.digit) begin
          n.phase = PH_FAIL;
        end else if (c == CH_EXP) begin
          n.phase = PH_EXPS;
          n.digit = 1'b0;
        end else begin
          n.phase = after_number(c);
        end
      end
      PH_EXPS: begin
        if (is_sign(c)) begin
          n.phase = PH_EXPD;
        end else if (is_digit(c)) begin
          n.digit = 1'b1;
          n.phase = PH_EXPD;
        end else begin
          n.phase = PH_FAIL;
        end
      end
      PH_EXPD: begin
        if (is_digit(c)) begin
          n.digit = 1'b1;
        end else if (!s.digit) begin
          n.phase = PH_FAIL;
        end else begin
          n.phase = after_number(c);
        end
      end
      PH_TRAIL: begin
        if (c != CH_SPACE) begin
          n.phase = (c == CH_NUL) ? PH_DONE : PH_FAIL;
        end
      end
      PH_FAIL, PH_DONE: begin
        n = s;
      end
      default: begin
        n.phase = PH_FAIL;
      end
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/cfnc_in_if.sv
interface cfnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink (input valid, input char_byte, input end_of_line, output ready);
endinterface

FILE: hdl/cfnc_out_if.sv
interface cfnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_index;
  logic       is_numeric;
  logic       column_overflow;
  logic       last_field;

  modport source (output valid, output column_index, output is_numeric,
                  output column_overflow, output last_field, input ready);
  modport sink (input valid, input column_index, input is_numeric,
                input column_overflow, input last_field, output ready);
endinterface

FILE: hdl/cfnc_scan.sv
`include "csv_field_number_classifier_top_assert.svh"

module cfnc_scan #(
  parameter int MAX_COLUMNS = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      separator,
  input  logic            accept,
  input  logic [7:0]      char_byte,
  input  logic            end_of_line,
  output cfnc_pkg::push_t push
);

  localparam int COL_TOP_INT = ((MAX_COLUMNS - 1) < 255) ? (MAX_COLUMNS - 1) : 255;
  localparam logic [7:0] COL_TOP = 8'(COL_TOP_INT);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eol;

  // field and line state
  logic [2:0] scan_phase;
  logic [1:0] point_count;
  logic       digit_seen;
  logic [7:0] column_count;
  logic       overflow_seen;

  cfnc_pkg::scan_t cur;
  cfnc_pkg::scan_t fed;
  cfnc_pkg::scan_t scan_next;
  logic            is_sep;
  logic            at_top;
  logic            verdict_sep;
  logic            verdict_eol;
  logic            ovf_sep;
  logic            ovf_after;
  logic [7:0]      col_after;
  logic [7:0]      column_count_next;
  logic            overflow_seen_next;
  cfnc_pkg::result_t r_sep;
  cfnc_pkg::result_t r_eol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_char <= char_byte;
      s1_eol  <= end_of_line;
    end
  end

  always_comb begin
    cur         = '{phase: scan_phase, points: point_count, digit: digit_seen};
    is_sep      = (s1_char == separator);
    fed         = cfnc_pkg::feed(cur, s1_char);
    verdict_sep = (cfnc_pkg::feed(cur, cfnc_pkg::CH_NUL).phase == cfnc_pkg::PH_DONE);
    verdict_eol = !is_sep &&
                  (cfnc_pkg::feed(fed, cfnc_pkg::CH_NUL).phase == cfnc_pkg::PH_DONE);
    at_top      = (column_count >= COL_TOP);
    ovf_sep     = overflow_seen | at_top;
    ovf_after   = is_sep ? ovf_sep : overflow_seen;
    col_after   = (is_sep && !at_top) ? (column_count + 8'd1) : column_count;

    r_sep = '{column_index: column_count, is_numeric: verdict_sep,
              column_overflow: ovf_sep, last_field: 1'b0};
    r_eol = '{column_index: col_after, is_numeric: verdict_eol,
              column_overflow: ovf_after, last_field: 1'b1};

    push.count  = s1_valid ? ({1'b0, is_sep} + {1'b0, s1_eol}) : 2'd0;
    push.first  = is_sep ? r_sep : r_eol;
    push.second = r_eol;

    scan_next          = cur;
    column_count_next  = column_count;
    overflow_seen_next = overflow_seen;
    if (s1_valid) begin
      if (s1_eol) begin
        scan_next          = '{phase: cfnc_pkg::PH_LEAD, points: 2'd0, digit: 1'b0};
        column_count_next  = 8'd0;
        overflow_seen_next = 1'b0;
      end else if (is_sep) begin
        scan_next          = '{phase: cfnc_pkg::PH_LEAD, points: 2'd0, digit: 1'b0};
        column_count_next  = col_after;
        overflow_seen_next = ovf_after;
      end else begin
        scan_next = fed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase    <= cfnc_pkg::PH_LEAD;
      point_count   <= 2'd0;
      digit_seen    <= 1'b0;
      column_count  <= 8'd0;
      overflow_seen <= 1'b0;
    end else begin
      scan_phase    <= scan_next.phase;
      point_count   <= scan_next.points;
      digit_seen    <= scan_next.digit;
      column_count  <= column_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  `CFNC_ASSERT_NEXT(a_eol_restarts_line, s1_valid && s1_eol, (column_count == 8'd0) && !overflow_seen && (scan_phase == cfnc_pkg::PH_LEAD), "line state not cleared after end of line")
  `CFNC_ASSERT_NOW(a_overflow_at_top, $rose(overflow_seen), $past(column_count) == COL_TOP, "overflow raised below the top column")
  `CFNC_ASSERT_NOW(a_column_bounded, 1'b1, column_count <= COL_TOP, "column counter past its top")

endmodule

FILE: hdl/cfnc_out_fifo.sv
`include "csv_field_number_classifier_top_assert.svh"

module cfnc_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  cfnc_pkg::push_t   push,
  input  logic              pop,
  output logic              not_empty,
  output logic              room,
  output cfnc_pkg::result_t head
);

  localparam int DEPTH = 8;
  localparam int PTR_W = $clog2(DEPTH);
  // the byte in the input register may make two results, the byte accepted behind it two more
  localparam logic [PTR_W:0] ROOM_LIMIT = (PTR_W + 1)'(DEPTH - 4);

  cfnc_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic [PTR_W:0]    count_next;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr_next;
  logic              do_pop;

  always_comb begin
    do_pop      = pop && not_empty;
    count_next  = count + {{(PTR_W - 1){1'b0}}, push.count} - {{PTR_W{1'b0}}, do_pop};
    wr_ptr_next = wr_ptr + {{(PTR_W - 2){1'b0}}, push.count};
    rd_ptr_next = rd_ptr + {{(PTR_W - 1){1'b0}}, do_pop};
  end

  assign not_empty = (count != '0);
  assign room      = (count <= ROOM_LIMIT);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + {{(PTR_W - 1){1'b0}}, 1'b1}] <= push.second;
    end
  end

  `CFNC_ASSERT_NOW(a_no_overrun, 1'b1, ({1'b0, count} + {{PTR_W{1'b0}}, push.count}) <= (PTR_W + 2)'(DEPTH), "result queue overrun")
  `CFNC_ASSERT_NEXT(a_push_keeps_data, (push.count != 2'd0) && !do_pop, count != '0, "pushed result lost")
  `CFNC_ASSERT_NOW(a_ptr_gap, 1'b1, (wr_ptr - rd_ptr) == count[PTR_W-1:0], "pointers disagree with fill count")

endmodule

FILE: hdl/csv_field_number_classifier_top.sv
// channel   dir  payload                                            handshake
// chars     in   char_byte[7:0], end_of_line                        valid/ready
// fields    out  column_index[7:0], is_numeric, column_overflow,    valid/ready
//                last_field
// separator cfg  separator_data[7:0] on separator_we                write only
//
// one byte item accepted per cycle while the result queue has room
// results pass through the input register, then the queue
// an item makes zero, one or two results; a separator on the last byte makes two
// ready drops when the eight-entry result queue passes half full; no clearing pass
// rst is synchronous and clears line state, queue and separator (back to comma)
module csv_field_number_classifier_top #(
  parameter int MAX_COLUMNS = 256
) (
  input  logic             clk,
  input  logic             rst,
  cfnc_in_if.sink          chars,
  cfnc_out_if.source       fields,
  input  logic             separator_we,
  input  logic [7:0]       separator_data
);

  logic              accept;
  logic              room;
  logic              not_empty;
  logic [7:0]        separator;
  cfnc_pkg::push_t   push;
  cfnc_pkg::result_t head;

  // separator register; the user writes it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      separator <= cfnc_pkg::SEP_RESET;
    end else if (separator_we) begin
      separator <= separator_data;
    end
  end

  // input side: take a byte whenever the queue can absorb its worst case
  assign chars.ready = room;
  assign accept      = chars.valid && room;

  // byte register plus field scan and column count
  cfnc_scan #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .separator   (separator),
    .accept      (accept),
    .char_byte   (chars.char_byte),
    .end_of_line (chars.end_of_line),
    .push        (push)
  );

  // result queue decouples the two sides
  cfnc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (fields.ready),
    .not_empty (not_empty),
    .room      (room),
    .head      (head)
  );

  // output side: head of the queue
  assign fields.valid           = not_empty;
  assign fields.column_index    = head.column_index;
  assign fields.is_numeric      = head.is_numeric;
  assign fields.column_overflow = head.column_overflow;
  assign fields.last_field      = head.last_field;

endmodule

FILE: tb/cfnc_field_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts every field verdict and compares in order
module cfnc_field_checker #(
  parameter int MAX_COLUMNS = 256
) (
  input  logic       clk,
  input  logic       rst,
  cfnc_in_if         chars,
  cfnc_out_if        fields,
  input  logic       separator_we,
  input  logic [7:0] separator_data,
  output int         outstanding,
  output int         mismatches
);

  localparam int TOP_COLUMN = (MAX_COLUMNS - 1 < 255) ? MAX_COLUMNS - 1 : 255;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] points;
    logic       digit;
  } number_scan_t;

  typedef struct packed {
    logic [7:0] column_index;
    logic       is_numeric;
    logic       column_overflow;
    logic       last_field;
  } field_verdict_t;

  logic [7:0]     sep_byte;
  number_scan_t   scan;
  int             column;
  logic           overflowed;
  field_verdict_t expected_verdicts[$];
  int             errors = 0;

  // what follows a finished mantissa or exponent
  function automatic logic [2:0] number_end(input logic [7:0] c);
    logic [2:0] ph;
    if (c == cfnc_pkg::CH_SPACE) begin
      ph = cfnc_pkg::PH_TRAIL;
    end else if (c == cfnc_pkg::CH_NUL) begin
      ph = cfnc_pkg::PH_DONE;
    end else begin
      ph = cfnc_pkg::PH_FAIL;
    end
    return ph;
  endfunction

  function automatic number_scan_t scan_next(input number_scan_t s, input logic [7:0] c);
    number_scan_t n;
    logic         digit_c;
    logic         sign_c;
    n = s;
    digit_c = (c >= cfnc_pkg::CH_ZERO) && (c <= cfnc_pkg::CH_NINE);
    sign_c = (c == cfnc_pkg::CH_PLUS) || (c == cfnc_pkg::CH_MINUS);
    case (s.phase)
      cfnc_pkg::PH_LEAD: begin
        if (sign_c) begin
          n.phase = cfnc_pkg::PH_MANT;
        end else if (digit_c) begin
          n.phase = cfnc_pkg::PH_MANT;
          n.digit = 1'b1;
        end else if (c == cfnc_pkg::CH_POINT) begin
          n.phase = cfnc_pkg::PH_MANT;
          n.points = 2'd1;
        end else if (c != cfnc_pkg::CH_SPACE) begin
          n.phase = cfnc_pkg::PH_FAIL;
        end
      end
      cfnc_pkg::PH_MANT: begin
        if (digit_c) begin
          n.digit = 1'b1;
        end else if (c == cfnc_pkg::CH_POINT) begin
          if (s.points < 2'd2) begin
            n.points = s.points + 2'd1;
          end
        end else if ((s.points > 2'd1) || !s.digit) begin
          n.phase = cfnc_pkg::PH_FAIL;
        end else if (c == cfnc_pkg::CH_EXP) begin
          n.phase = cfnc_pkg::PH_EXPS;
          n.digit = 1'b0;
        end else begin
          n.phase = number_end(c);
        end
      end
      cfnc_pkg::PH_EXPS: begin
        if (sign_c) begin
          n.phase = cfnc_pkg::PH_EXPD;
        end else if (digit_c) begin
          n.phase = cfnc_pkg::PH_EXPD;
          n.digit = 1'b1;
        end else begin
          n.phase = cfnc_pkg::PH_FAIL;
        end
      end
      cfnc_pkg::PH_EXPD: begin
        if (digit_c) begin
          n.digit = 1'b1;
        end else if (!s.digit) begin
          n.phase = cfnc_pkg::PH_FAIL;
        end else begin
          n.phase = number_end(c);
        end
      end
      cfnc_pkg::PH_TRAIL: begin
        if (c != cfnc_pkg::CH_SPACE) begin
          n.phase = (c == cfnc_pkg::CH_NUL) ? cfnc_pkg::PH_DONE : cfnc_pkg::PH_FAIL;
        end
      end
      cfnc_pkg::PH_FAIL, cfnc_pkg::PH_DONE: begin
      end
      default: begin
        n.phase = cfnc_pkg::PH_FAIL;
      end
    endcase
    return n;
  endfunction

  task automatic clear_scan();
    scan = '{phase: cfnc_pkg::PH_LEAD, points: 2'd0, digit: 1'b0};
  endtask

  // a field ends: a zero byte settles the verdict
  task automatic close_field(input logic last);
    field_verdict_t v;
    scan = scan_next(scan, cfnc_pkg::CH_NUL);
    v.column_index = 8'(column);
    v.is_numeric = (scan.phase == cfnc_pkg::PH_DONE);
    v.column_overflow = overflowed;
    v.last_field = last;
    expected_verdicts.insert(expected_verdicts.size(), v);
    clear_scan();
  endtask

  task automatic take_byte(input logic [7:0] c, input logic eol);
    if (c == sep_byte) begin
      if (column >= TOP_COLUMN) begin
        overflowed = 1'b1;
      end
      close_field(1'b0);
      if (column < TOP_COLUMN) begin
        column++;
      end
    end else begin
      scan = scan_next(scan, c);
    end
    if (eol) begin
      close_field(1'b1);
      column = 0;
      overflowed = 1'b0;
    end
  endtask

  task automatic check_field(input logic [7:0] col, input logic num, input logic ovf,
                             input logic last);
    field_verdict_t want;
    if (expected_verdicts.size() == 0) begin
      $display("%0t: unexpected field col=%0d num=%0b ovf=%0b last=%0b",
               $time, col, num, ovf, last);
      errors++;
    end else begin
      want = expected_verdicts.pop_front();
      if (col !== want.column_index || num !== want.is_numeric ||
          ovf !== want.column_overflow || last !== want.last_field) begin
        // order: column, numeric, overflow, last
        $display("%0t: field mismatch expected %0d/%0b/%0b/%0b got %0d/%0b/%0b/%0b",
                 $time, want.column_index, want.is_numeric, want.column_overflow,
                 want.last_field, col, num, ovf, last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sep_byte = cfnc_pkg::SEP_RESET;
      clear_scan();
      column = 0;
      overflowed = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (separator_we) begin
        sep_byte = separator_data;
      end
      if (chars.valid && chars.ready) begin
        take_byte(chars.char_byte, chars.end_of_line);
      end
      if (fields.valid && fields.ready) begin
        check_field(fields.column_index, fields.is_numeric, fields.column_overflow,
                    fields.last_field);
      end
    end
    outstanding <= expected_verdicts.size();
    mismatches <= errors;
  end

endmodule

FILE: tb/tb_csv_field_number_classifier_top.sv
`timescale 1ns / 1ps

// stimulus and verdict; all prediction and checking lives in the checker
module tb_csv_field_number_classifier_top;

  localparam int MAX_COLUMNS = 256;
  localparam int TOP_COLUMN = (MAX_COLUMNS - 1 < 255) ? MAX_COLUMNS - 1 : 255;
  localparam int IDLE_PERCENT = 13;
  // long receiver hold, well past the eight-entry result queue
  localparam int LONG_HOLD = 120;
  // margin for the pass through the input register and queue, for items that leave no result behind
  localparam int SETTLE_CYCLES = 6;
  localparam logic [7:0] SEP_TOP = 8'hFF;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LETTER_X = 8'h78;

  logic       clk;
  logic       rst;
  logic       sep_we;
  logic [7:0] sep_data;
  int         outstanding;
  int         mismatches;

  // stimulus control shared with the receiver process
  bit         quiet;
  bit         hold_go;
  int         items_sent;
  logic [7:0] cur_sep;
  logic [7:0] line_q[$];

  cfnc_in_if  chars_if();
  cfnc_out_if fields_if();

  csv_field_number_classifier_top #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .fields(fields_if),
    .separator_we(sep_we),
    .separator_data(sep_data)
  );

  cfnc_field_checker #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .fields(fields_if),
    .separator_we(sep_we),
    .separator_data(sep_data),
    .outstanding(outstanding),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("csv_field_number_classifier_top regression: fail");
    $finish;
  end

  // result side: random back-pressure, plus a long hold on request
  initial begin
    int hold_left;
    hold_left = 0;
    fields_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        fields_if.ready <= 1'b0;
        hold_left--;
      end else if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
        fields_if.ready <= 1'b0;
      end else begin
        fields_if.ready <= 1'b1;
      end
    end
  end

  // offer one byte item and wait for it to be taken; valid stays up afterwards
  task automatic send_char(input logic [7:0] c, input logic eol);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_byte <= c;
    chars_if.end_of_line <= eol;
    @(posedge clk);
    while (!chars_if.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // one more byte at the end of the line being built
  task automatic append_byte(input logic [7:0] c);
    line_q.insert(line_q.size(), c);
  endtask

  // end-of-line mark rides on the last byte; an empty line is a lone separator
  task automatic send_line();
    if (line_q.size() == 0) begin
      append_byte(cur_sep);
    end
    foreach (line_q[i]) begin
      send_char(line_q[i], i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      append_byte(s[i]);
    end
  endtask

  // bytes that matter to the number grammar, with the odd random one
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: c = cfnc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      4:          c = cfnc_pkg::CH_SPACE;
      5:          c = cfnc_pkg::CH_PLUS;
      6:          c = cfnc_pkg::CH_MINUS;
      7:          c = cfnc_pkg::CH_POINT;
      8:          c = cfnc_pkg::CH_EXP;
      9:          c = CH_UPPER_E;
      10:         c = cfnc_pkg::CH_NUL;
      default:    c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic add_digits(input int n);
    repeat (n) begin
      append_byte(cfnc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // mostly well-formed numbers with random shape, sometimes mutated
  task automatic add_numeric_field();
    int start;
    start = line_q.size();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
      append_byte(cfnc_pkg::CH_SPACE);
    end
    if ($urandom_range(0, 2) == 0) begin
      append_byte($urandom_range(0, 1) ? cfnc_pkg::CH_PLUS : cfnc_pkg::CH_MINUS);
    end
    add_digits($urandom_range(0, 4));
    if ($urandom_range(0, 1) == 0) begin
      append_byte(cfnc_pkg::CH_POINT);
      add_digits($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) begin
        append_byte(cfnc_pkg::CH_POINT);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      append_byte(cfnc_pkg::CH_EXP);
      if ($urandom_range(0, 1) == 0) begin
        append_byte($urandom_range(0, 1) ? cfnc_pkg::CH_PLUS : cfnc_pkg::CH_MINUS);
      end
      add_digits($urandom_range(0, 3));
    end
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
      append_byte(cfnc_pkg::CH_SPACE);
    end
    // broken sequences: one byte replaced, or a zero byte with junk after it
    if (line_q.size() > start && $urandom_range(0, 9) == 0) begin
      line_q[$urandom_range(start, line_q.size() - 1)] = pick_char();
    end
    if ($urandom_range(0, 11) == 0) begin
      append_byte(cfnc_pkg::CH_NUL);
      repeat ($urandom_range(0, 2)) begin
        append_byte(pick_char());
      end
    end
  endtask

  task automatic random_line();
    int n;
    n = $urandom_range(1, 5);
    for (int f = 0; f < n; f++) begin
      if (f > 0) begin
        append_byte(cur_sep);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: add_numeric_field();
        6, 7: begin
          repeat ($urandom_range(1, 4)) begin
            append_byte(pick_char());
          end
        end
        8: begin
          repeat ($urandom_range(1, 3)) begin
            append_byte(8'($urandom_range(0, 255)));
          end
        end
        default: begin
        end
      endcase
    end
    // separator on the last byte: the line closes with an empty field
    if ($urandom_range(0, 9) == 0) begin
      append_byte(cur_sep);
    end
    send_line();
  endtask

  // more fields than the column counter holds, so it saturates
  task automatic wide_line();
    repeat ($urandom_range(TOP_COLUMN + 2, TOP_COLUMN + 30)) begin
      case ($urandom_range(0, 3))
        0: append_byte(cfnc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        1: append_byte(CH_LETTER_X);
        default: begin
        end
      endcase
      append_byte(cur_sep);
    end
    if ($urandom_range(0, 1) == 0) begin
      append_byte(cfnc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    send_line();
  endtask

  // sender stops until every predicted field is back and the pipe is quiet
  task automatic drain_results();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] v);
    sep_we <= 1'b1;
    sep_data <= v;
    @(posedge clk);
    sep_we <= 1'b0;
    cur_sep = v;
  endtask

  // one separator setting, a budget of items, optional quiet stretch, hold and wide line
  task automatic run_phase(input logic [7:0] sep, input int budget, input bit no_idle,
                           input bit with_hold, input bit with_wide);
    int start;
    drain_results();
    write_separator(sep);
    quiet = no_idle;
    if (with_hold) begin
      hold_go = 1'b1;
    end
    start = items_sent;
    if (with_wide) begin
      wide_line();
    end
    while (items_sent - start < budget) begin
      random_line();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    sep_we = 1'b0;
    sep_data = cfnc_pkg::SEP_RESET;
    chars_if.valid = 1'b0;
    chars_if.char_byte = cfnc_pkg::CH_NUL;
    chars_if.end_of_line = 1'b0;
    quiet = 1'b0;
    hold_go = 1'b0;
    items_sent = 0;
    cur_sep = cfnc_pkg::SEP_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed line on the reset separator: signed number with exponent and
    // trailing space, plain text, a zero byte that ends the check early, a
    // point-only mantissa, and a separator carrying the end-of-line mark
    add_text(" -1.5e+3 ,ab,7");
    append_byte(cfnc_pkg::CH_NUL);
    add_text("9,.e1,");
    send_line();
    // end of line on an ordinary byte, with the top byte value
    add_text("5");
    append_byte(SEP_TOP);
    send_line();

    run_phase(cfnc_pkg::SEP_RESET, 420, 1'b0, 1'b0, 1'b1);
    // zero byte as separator
    run_phase(cfnc_pkg::CH_NUL, 300, 1'b0, 1'b0, 1'b0);
    // top separator value, no random idling, receiver hold fills the queue
    run_phase(SEP_TOP, 300, 1'b1, 1'b1, 1'b0);
    run_phase(cfnc_pkg::CH_SPACE, 200, 1'b0, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 200, 1'b0, 1'b0, 1'b0);
    run_phase(cfnc_pkg::SEP_RESET, 450, 1'b0, 1'b1, 1'b1);

    drain_results();
    if (mismatches == 0) begin
      $display("csv_field_number_classifier_top regression: pass");
    end else begin
      $display("csv_field_number_classifier_top regression: fail");
    end
    $finish;
  end

endmodule
